// ===== rtl/core/sha_pkg.sv =====
// sha_pkg: constants, round table and helper functions for the sha-256 core
// no dependencies
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int LenPos     = 56;
  localparam int Rounds     = 64;
  localparam int DigestWords = 8;
  localparam logic [7:0] PadByte = 8'h80;

  // controller to datapath commands
  typedef struct packed {
    logic       load_byte;   // write in_data_byte at the fill position
    logic       pad_byte;    // write padding byte at pad position
    logic [7:0] pad_value;
    logic [5:0] pad_pos;
    logic       start_blk;   // copy chaining words into working vars, load schedule
    logic       round_en;    // one round of compression
    logic [5:0] round_idx;
    logic       finish_blk;  // add working vars into chaining words
    logic       restart;     // back to initial hash values
    logic       len_byte;    // write a length byte at pad position
    logic [2:0] len_idx;
  } sha_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [0:63];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [0:7];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_message_digest.sv =====
// sha256_message_digest: sha-256 over a byte stream, top level
// depends on sha_pkg, sha_ctrl, sha_datapath
//
//  channel | direction | payload
//  in_     | input     | data_byte[7:0], byte_present, end_of_message
//  out_    | output    | digest_word[31:0], word_index[2:0], last_word
//
// a byte transaction is written straight into the block buffer; a full block adds
// the start, round loop (one round a cycle in the datapath) and finish states. end
// of message adds the padding sweep (one buffer byte a cycle) and one or two
// compressions, then eight output words. reset restores the initial hash values;
// the input is stalled while a block, padding or the digest output is in progress.
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_cmd_t    cmd;
  logic [5:0]  fill_pos;
  logic [63:0] bit_count;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_byte_present, .in_end_of_message,
    .out_valid, .out_stall, .out_word_index, .out_last_word,
    .fill_pos, .bit_count, .cmd
  );

  sha_datapath u_dp (
    .clk, .in_data_byte, .fill_pos, .bit_count, .cmd,
    .rd_idx(out_word_index), .rd_word(out_digest_word)
  );

endmodule

// ===== rtl/core/sha_datapath.sv =====
// sha_datapath: block buffer, message schedule window, working variables and
// chaining words; depends on sha_pkg
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  fill_pos,
  input  logic [63:0] bit_count,
  input  sha_cmd_t    cmd,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);

  // block buffer held as sixteen big-endian words, one byte lane written a cycle
  logic [31:0] buf_r [0:15];
  logic [31:0] w_r [0:15];
  logic [31:0] v_r [0:7];
  logic [31:0] h_r [0:7];
  logic [31:0] w_new, t1, t2, wt;
  logic [7:0]  len_b;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_data;

  assign wt = w_r[0];
  assign len_b = bit_count[6'd56 - {cmd.len_idx, 3'b000} +: 8];

  // next schedule word and round sums
  always_comb begin
    w_new = w_r[0] + (ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3))
          + w_r[9] + (ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10));
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(cmd.round_idx) + wt;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // byte write select: message byte, padding byte or length byte
  always_comb begin
    wr_en = cmd.load_byte | cmd.pad_byte | cmd.len_byte;
    wr_pos = cmd.load_byte ? fill_pos : cmd.pad_pos;
    if (cmd.load_byte) begin
      wr_data = in_data_byte;
    end else if (cmd.pad_byte) begin
      wr_data = cmd.pad_value;
    end else begin
      wr_data = len_b;
    end
  end

  // byte buffer writes, first byte of a word in the top lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (cmd.start_blk) begin
      for (int i = 0; i < 16; i++) w_r[i] <= buf_r[i];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else if (cmd.finish_blk) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

// ===== rtl/core/sha_ctrl.sv =====
// sha_ctrl: sequencer for byte intake, padding, rounds and digest output
// depends on sha_pkg
module sha_ctrl
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic [5:0]  fill_pos,
  output logic [63:0] bit_count,
  output sha_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LEN = 3'd2,
                         S_START = 3'd3, S_ROUND = 3'd4, S_FIN = 3'd5,
                         S_OUT = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;       // fill count
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  pos_r, pos_nxt;       // padding / round index
  logic        eom_r, eom_nxt;       // padding pending
  logic        pad_r, pad_nxt;       // padding under way, more blocks may follow
  logic        final_r, final_nxt;   // this compression carries the length
  logic [2:0]  oidx_r, oidx_nxt;
  logic        acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign fill_pos = cnt_r;
  assign bit_count = bits_r;
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    bits_nxt = bits_r;
    pos_nxt = pos_r;
    eom_nxt = eom_r;
    pad_nxt = pad_r;
    final_nxt = final_r;
    oidx_nxt = oidx_r;
    cmd = '0;
    cmd.round_idx = pos_r;
    cmd.pad_pos = pos_r;
    cmd.len_idx = pos_r[2:0] ;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_byte_present) begin
            cmd.load_byte = 1'b1;
            bits_nxt = bits_r + 64'd8;
            cnt_nxt = cnt_r + 6'd1;
          end
          eom_nxt = in_end_of_message;
          pad_nxt = 1'b0;
          final_nxt = 1'b0;
          if (in_byte_present && cnt_r == 6'd63) begin
            state_nxt = S_START;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
            pos_nxt = in_byte_present ? cnt_r + 6'd1 : cnt_r;
          end
        end
      end
      // 0x80 then zeros up to length field or block end
      S_PAD: begin
        cmd.pad_byte = 1'b1;
        cmd.pad_value = eom_r ? PadByte : 8'h00;
        eom_nxt = 1'b0;
        pad_nxt = 1'b1;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          state_nxt = S_START;
        end else if (pos_r == 6'(LenPos - 1)) begin
          state_nxt = S_LEN;
          final_nxt = 1'b1;
        end
      end
      S_LEN: begin
        cmd.len_byte = 1'b1;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) state_nxt = S_START;
      end
      S_START: begin
        cmd.start_blk = 1'b1;
        pos_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_blk = 1'b1;
        cnt_nxt = '0;
        if (final_r) begin
          state_nxt = S_OUT;
          oidx_nxt = '0;
        end else if (eom_r || pad_r) begin
          // end mark came with the 64th byte, or padding overflowed
          state_nxt = S_PAD;
          pos_nxt = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.restart = 1'b1;
            bits_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // initial hash values loaded while in reset
    if (!rst_n) cmd.restart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      bits_r <= '0;
      pos_r <= '0;
      eom_r <= 1'b0;
      pad_r <= 1'b0;
      final_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      bits_r <= bits_nxt;
      pos_r <= pos_nxt;
      eom_r <= eom_nxt;
      pad_r <= pad_nxt;
      final_r <= final_nxt;
      oidx_r <= oidx_nxt;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for the sha-256 byte stream digest block
// depends on sha_pkg and sha256_message_digest; own digest predictor, no files
`timescale 1ns / 1ps

module tb_top;
  import sha_pkg::*;

  localparam int NumRandom = 170;
  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       typed;      // expected first digest word typed in
    logic [31:0] first_word;
  } stim_row_t;

  // predictor state
  logic [31:0] hash_words [8];
  logic [7:0]  msg_block [64];
  int unsigned fill_count;
  logic [63:0] bit_length;

  digest_beat_t digest_q [$];
  logic [31:0]  typed_first_q [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           stim_done = 1'b0;
  bit           rx_hold_long = 1'b0;

  always #4 clk = ~clk;

  sha256_message_digest dut (.*);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_words
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_words[i] = init_h(i[2:0]);
    fill_count = 0;
    bit_length = '0;
  endtask

  // predict the digest beats caused by one accepted transaction
  task automatic predict_digest(input logic [7:0] data, input logic present,
                                input logic eom);
    int unsigned pos;
    digest_beat_t beat;
    if (present) begin
      msg_block[fill_count] = data;
      fill_count++;
      bit_length += 64'd8;
      if (fill_count == BlockBytes) begin
        compress_block();
        fill_count = 0;
      end
    end
    if (eom) begin
      pos = fill_count;
      msg_block[pos++] = PadByte;
      if (pos > LenPos) begin
        while (pos < BlockBytes) msg_block[pos++] = 8'h00;
        compress_block();
        pos = 0;
      end
      while (pos < LenPos) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[LenPos+i] = bit_length[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < DigestWords; i++) begin
        beat.word  = hash_words[i];
        beat.index = i[2:0];
        beat.last  = (i == 7);
        digest_q.push_back(beat);
      end
      restart_digest();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (want.index == 3'd0 && typed_first_q.size() != 0) begin
          if (out_digest_word !== typed_first_q[0])
            report_mismatch("typed first word", out_digest_word, typed_first_q[0]);
          void'(typed_first_q.pop_front());
        end
        if (out_digest_word !== want.word)
          report_mismatch("digest_word", out_digest_word, want.word);
        if (out_word_index !== want.index)
          report_mismatch("word_index", out_word_index, want.index);
        if (out_last_word !== want.last)
          report_mismatch("last_word", out_last_word, want.last);
      end
    end
    if (rx_hold_long) out_stall <= ($urandom_range(0, 9) != 0);
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 1) == 1);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (stim_done) rx_hold_long <= 1'b0;
    else if ($urandom_range(0, 299) == 0) rx_hold_long <= ~rx_hold_long;
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present,
                           input logic eom);
    int gap;
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    predict_digest(data, present, eom);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1,
                (i == len - 1) && ($urandom_range(0, 1) == 1));
    end
    if (digest_q.size() == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    stim_row_t rows [$];
    int sent;
    int len;
    restart_digest();
    // empty message, "abc", idle item, byte extremes, end mark on an idle item
    rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
    rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'hff, 1'b0, 1'b0, 1'b0, '0});
    rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf});
    rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h55, 1'b1, 1'b0, 1'b0, '0});
    rows.push_back('{8'haa, 1'b0, 1'b1, 1'b0, '0});
    rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, '0});
    rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].typed) typed_first_q.push_back(rows[k].first_word);
      send_item(rows[k].data, rows[k].present, rows[k].eom);
    end
    // messages ending exactly around the length field and block boundary
    send_message(55);
    send_message(56);
    send_message(64);

    // sender holds off until every digest word has drained
    in_valid <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk);

    // random messages, mostly short with a few long ones
    sent = 0;
    while (sent < NumRandom) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_message(len);
      sent += len + 1;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_datapath.sv
rtl/core/sha_ctrl.sv
rtl/core/sha256_message_digest.sv
verif/tb_top.sv
